### rtl/core/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared constants, types and the pixel doubling function for the glyph
// rounding core.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // Default glyph geometry of the source character cell.
  localparam int unsigned GlyphRows = 10;
  localparam int unsigned GlyphCols = 6;

  // Largest geometry the design supports; queue entries are sized for it.
  localparam int unsigned MaxRows = 16;
  localparam int unsigned MaxCols = 16;
  localparam int unsigned IdxW    = $clog2(MaxRows);

  // Fixed widths of the payload fields.
  localparam int unsigned RowBitsW  = 6;
  localparam int unsigned PixelRowW = 12;
  localparam int unsigned OutRowW   = 5;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // What the back has to produce for one accepted source row.
  typedef struct packed {
    logic emit_held;  // pair for the held row, its lower neighbour has arrived
    logic emit_last;  // pair for the last row of the glyph itself
  } tgr_flags_t;

  // One request passed from the front to the back.
  typedef struct packed {
    tgr_flags_t           flags;
    logic [IdxW-1:0]      idx;        // rows of the glyph seen before this one
    logic [MaxCols-1:0]   above_row;
    logic [MaxCols-1:0]   held_row;
    logic                 held_rnd;
    logic [MaxCols-1:0]   new_row;
    logic                 new_rnd;
  } tgr_entry_t;

  // Doubles one source row into one output row. Bit p of a row is the pixel
  // p places from the right edge. vert is the vertical neighbour row on the
  // side of this output row (above for the upper half, below for the lower).
  // A lit pixel lights both output bits; with rounding an unlit pixel lights
  // the half towards a side whose orthogonal neighbours are both lit while
  // the diagonal one is not. Pixels outside the glyph are unlit.
  function automatic logic [2*MaxCols-1:0] tgr_expand(
    input logic [MaxCols-1:0] vert,
    input logic [MaxCols-1:0] cur,
    input logic               rnd,
    input int unsigned        cols
  );
    logic [2*MaxCols-1:0] res;
    logic                 w;
    logic                 e;
    logic                 vw;
    logic                 ve;
    res = '0;
    for (int unsigned p = 0; p < MaxCols; p++) begin
      w  = 1'b0;
      vw = 1'b0;
      e  = 1'b0;
      ve = 1'b0;
      if ((p + 1 < cols) && (p + 1 < MaxCols)) begin
        w  = cur[p+1];
        vw = vert[p+1];
      end
      if (p > 0) begin
        e  = cur[p-1];
        ve = vert[p-1];
      end
      if (p < cols) begin
        if (cur[p]) begin
          res[2*p+1] = 1'b1;
          res[2*p]   = 1'b1;
        end else if (rnd) begin
          res[2*p+1] = vert[p] & w & ~vw;
          res[2*p]   = vert[p] & e & ~ve;
        end
      end
    end
    return res;
  endfunction

endpackage

### rtl/core/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front
// Accepts source rows, keeps the row above and the held row, and turns each
// row into a request for the back when it causes output rows.
// ----------------------------------------------------------------------------
module tgr_front #(
  parameter int unsigned GLYPH_ROWS = tgr_pkg::GlyphRows,
  parameter int unsigned GLYPH_COLS = tgr_pkg::GlyphCols
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tgr_pkg::RowBitsW-1:0]   row_bits_i,
  input  logic                           rounding_on_i,
  output logic                           push_o,
  output tgr_pkg::tgr_entry_t            push_entry_o,
  input  logic                           q_full_i
);

  localparam int unsigned CntW = $clog2(GLYPH_ROWS);
  localparam logic [CntW-1:0] LastIdx = CntW'(GLYPH_ROWS - 1);

  logic [GLYPH_COLS-1:0] above_q, above_d;
  logic [GLYPH_COLS-1:0] held_q, held_d;
  logic                  held_rnd_q, held_rnd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [GLYPH_COLS-1:0] row_m;
  logic                  accept;
  logic                  is_last;

  // Bits beyond the glyph width are ignored, missing ones read as unlit.
  always_comb begin
    row_m = '0;
    for (int unsigned i = 0; i < GLYPH_COLS; i++) begin
      if (i < tgr_pkg::RowBitsW) begin
        row_m[i] = row_bits_i[i];
      end
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign is_last    = (cnt_q == LastIdx);

  // Classify the row and build the request for the back.
  always_comb begin
    push_entry_o                 = '0;
    push_entry_o.flags.emit_held = (cnt_q != '0);
    push_entry_o.flags.emit_last = is_last;
    push_entry_o.idx             = tgr_pkg::IdxW'(cnt_q);
    push_entry_o.above_row       = tgr_pkg::MaxCols'(above_q);
    push_entry_o.held_row        = tgr_pkg::MaxCols'(held_q);
    push_entry_o.held_rnd        = held_rnd_q;
    push_entry_o.new_row         = tgr_pkg::MaxCols'(row_m);
    push_entry_o.new_rnd         = rounding_on_i;
  end

  // The first row of a glyph causes no output and needs no request.
  assign push_o = accept & ((cnt_q != '0) | is_last);

  // Row window update; the last row returns the window to its empty state.
  always_comb begin
    above_d    = above_q;
    held_d     = held_q;
    held_rnd_d = held_rnd_q;
    cnt_d      = cnt_q;
    if (accept) begin
      if (is_last) begin
        above_d    = '0;
        held_d     = '0;
        held_rnd_d = 1'b0;
        cnt_d      = '0;
      end else begin
        above_d    = held_q;
        held_d     = row_m;
        held_rnd_d = rounding_on_i;
        cnt_d      = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q    <= '0;
      held_q     <= '0;
      held_rnd_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      above_q    <= above_d;
      held_q     <= held_d;
      held_rnd_q <= held_rnd_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

### rtl/core/tgr_queue.sv
// ----------------------------------------------------------------------------
// tgr_queue
// Short first-in first-out queue of requests between the front and the back.
// ----------------------------------------------------------------------------
module tgr_queue #(
  parameter int unsigned DEPTH = tgr_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tgr_pkg::tgr_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                not_empty_o,
  output tgr_pkg::tgr_entry_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  tgr_pkg::tgr_entry_t mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntW'(DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

  // Pointer and fill level update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

### rtl/core/tgr_back.sv
// ----------------------------------------------------------------------------
// tgr_back
// Steps through the output rows of the request at the head of the queue,
// one doubled row per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module tgr_back #(
  parameter int unsigned GLYPH_ROWS = tgr_pkg::GlyphRows,
  parameter int unsigned GLYPH_COLS = tgr_pkg::GlyphCols
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  tgr_pkg::tgr_entry_t            head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tgr_pkg::PixelRowW-1:0]  pixel_row_o,
  output logic [tgr_pkg::OutRowW-1:0]    out_row_o,
  output logic                           run_last_o,
  output logic                           glyph_last_o
);

  localparam logic [tgr_pkg::OutRowW-1:0] LastPairLine =
    tgr_pkg::OutRowW'(2 * (GLYPH_ROWS - 1));
  localparam logic [tgr_pkg::OutRowW-1:0] LastLine =
    tgr_pkg::OutRowW'(2 * GLYPH_ROWS - 1);

  // Step codes: upper and lower row of the held row, then of the last row.
  localparam logic [1:0] StHeldTop = 2'd0;
  localparam logic [1:0] StHeldBot = 2'd1;
  localparam logic [1:0] StLastTop = 2'd2;
  localparam logic [1:0] StLastBot = 2'd3;

  logic [1:0]                     step_q, step_d;
  logic [1:0]                     step;
  logic                           step_end;
  logic                           advance;
  logic [tgr_pkg::MaxCols-1:0]    vert;
  logic [tgr_pkg::MaxCols-1:0]    cur;
  logic                           rnd;
  logic [2*tgr_pkg::MaxCols-1:0]  expanded;
  logic [tgr_pkg::OutRowW-1:0]    base;
  logic [tgr_pkg::OutRowW-1:0]    line;
  logic                           out_valid_q, out_valid_d;
  logic [tgr_pkg::PixelRowW-1:0]  pixel_q;
  logic [tgr_pkg::OutRowW-1:0]    line_q;
  logic                           run_last_q;
  logic                           glyph_last_q;

  // A request without the held pair starts straight at the last row's pair.
  always_comb begin
    step = step_q;
    if (step_q == StHeldTop && !head_i.flags.emit_held) begin
      step = StLastTop;
    end
  end

  always_comb begin
    case (step)
      StHeldBot: step_end = ~head_i.flags.emit_last;
      StLastBot: step_end = 1'b1;
      default:   step_end = 1'b0;
    endcase
  end

  assign advance = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o   = advance & step_end;

  // Pick the source row and its vertical neighbour for this step.
  always_comb begin
    case (step)
      StHeldTop: begin
        cur  = head_i.held_row;
        rnd  = head_i.held_rnd;
        vert = head_i.above_row;
      end
      StHeldBot: begin
        cur  = head_i.held_row;
        rnd  = head_i.held_rnd;
        vert = head_i.new_row;
      end
      StLastTop: begin
        cur  = head_i.new_row;
        rnd  = head_i.new_rnd;
        vert = head_i.flags.emit_held ? head_i.held_row : '0;
      end
      default: begin
        cur  = head_i.new_row;
        rnd  = head_i.new_rnd;
        vert = '0;
      end
    endcase
  end

  assign expanded = tgr_pkg::tgr_expand(vert, cur, rnd, GLYPH_COLS);

  // Output row index: twice the source row, plus one for the lower half.
  always_comb begin
    base = tgr_pkg::OutRowW'(head_i.idx) - 1'b1;
    if (step[1]) begin
      line = LastPairLine | tgr_pkg::OutRowW'(step[0]);
    end else begin
      line = {base[tgr_pkg::OutRowW-2:0], step[0]};
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = step_end ? StHeldTop : step + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StHeldTop;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pixel_q      <= expanded[tgr_pkg::PixelRowW-1:0];
      line_q       <= line;
      run_last_q   <= step_end;
      glyph_last_q <= (line == LastLine);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_row_o  = pixel_q;
  assign out_row_o    = line_q;
  assign run_last_o   = run_last_q;
  assign glyph_last_o = glyph_last_q;

endmodule

### rtl/core/teletext_glyph_rounding_core.sv
// ----------------------------------------------------------------------------
// teletext_glyph_rounding_core
// Doubles character cells to twice their width and height with diagonal
// rounding of the staircase edges.
// ----------------------------------------------------------------------------
// Source rows of a glyph arrive top row first, GLYPH_ROWS to a glyph, each
// with its rounding flag. The first row of a glyph gives no output; each
// later row releases the two doubled rows of the row above it, and the last
// row releases four: the pair of the row above and then its own pair, with
// an unlit row below it. Output rows leave one per cycle from a registered
// stage while rows are pending and out_stall_i is low; a two-request queue
// between the input side and the output side lets a new row be taken while
// earlier rows are still being sent.
module teletext_glyph_rounding_core #(
  parameter int unsigned GLYPH_ROWS = tgr_pkg::GlyphRows,
  parameter int unsigned GLYPH_COLS = tgr_pkg::GlyphCols
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tgr_pkg::RowBitsW-1:0]   row_bits_i,
  input  logic                           rounding_on_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tgr_pkg::PixelRowW-1:0]  pixel_row_o,
  output logic [tgr_pkg::OutRowW-1:0]    out_row_o,
  output logic                           run_last_o,
  output logic                           glyph_last_o
);

  localparam logic [tgr_pkg::OutRowW-1:0] LastLine =
    tgr_pkg::OutRowW'(2 * GLYPH_ROWS - 1);

  logic                push;
  tgr_pkg::tgr_entry_t push_entry;
  logic                q_full;
  logic                pop;
  logic                head_valid;
  tgr_pkg::tgr_entry_t head;

  tgr_front #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .GLYPH_COLS (GLYPH_COLS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .row_bits_i    (row_bits_i),
    .rounding_on_i (rounding_on_i),
    .push_o        (push),
    .push_entry_o  (push_entry),
    .q_full_i      (q_full)
  );

  tgr_queue #(
    .DEPTH (tgr_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .not_empty_o  (head_valid),
    .head_o       (head)
  );

  tgr_back #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .GLYPH_COLS (GLYPH_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_row_o  (pixel_row_o),
    .out_row_o    (out_row_o),
    .run_last_o   (run_last_o),
    .glyph_last_o (glyph_last_o)
  );

  // The final row of a glyph always closes the run of its source row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && glyph_last_o) |-> run_last_o)
    else $error("glyph end without run end");

  // The upper row of a pair never ends a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_row_o[0]) |-> !run_last_o)
    else $error("run ended on an upper row");

  // The glyph end flag marks exactly the last output row index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (glyph_last_o == (out_row_o == LastLine)))
    else $error("glyph end flag and row index disagree");

  // A request is only released when the queue holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("request released from an empty queue");

endmodule
